// ===== rtl/jpdr_pkg.sv =====
`default_nettype none

package jpdr_pkg;

    localparam int EtaW   = 12;
    localparam int PhiW   = 11;
    localparam int DistW  = 23;
    localparam int SumW   = 25;
    localparam int IndexW = 4;

    localparam logic [11:0] PiFix    = 12'd804;
    localparam logic [11:0] TwoPiFix = 12'd1608;
    localparam logic [DistW-1:0] DistReset = 23'd10486;

    typedef struct packed {
        logic store;
        logic start;
        logic issue;
        logic finish;
    } cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_busy;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/jpdr_ram.sv =====
`default_nettype none

module jpdr_ram #(
    parameter int WIDTH = 23,
    parameter int DEPTH = 16
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jpdr_ctrl.sv =====
`default_nettype none

module jpdr_ctrl #(
    parameter int MAX_PARTONS = 16
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_op,
    input  wire logic              out_ready,
    input  wire jpdr_pkg::status_t status,
    input  wire logic [$clog2(MAX_PARTONS + 1)-1:0] count,
    output logic                   in_ready,
    output jpdr_pkg::cmd_t         cmd,
    output logic [((MAX_PARTONS > 1) ? $clog2(MAX_PARTONS) : 1)-1:0] rd_addr
);

    localparam int AW = (MAX_PARTONS > 1) ? $clog2(MAX_PARTONS) : 1;
    localparam int CW = $clog2(MAX_PARTONS + 1);

    typedef enum logic [1:0] {
        IDLE,
        SCAN,
        DRAIN
    } state_t;

    state_t        state_reg, state_next;
    logic [CW-1:0] issue_reg, issue_next;
    logic          accept;
    logic [AW+CW-1:0] addr_ext;

    assign in_ready = (state_reg == IDLE) && (!status.out_busy || out_ready);
    assign accept   = in_valid && in_ready;
    assign addr_ext = {{AW{1'b0}}, issue_reg};
    assign rd_addr  = addr_ext[AW-1:0];

    always_comb
    begin
        state_next = state_reg;
        issue_next = issue_reg;
        cmd        = '0;
        cmd.store  = accept && !in_op;
        cmd.start  = accept && in_op;
        case (state_reg)
            IDLE:
            begin
                if (accept && in_op)
                begin
                    state_next = SCAN;
                    issue_next = '0;
                end
            end
            SCAN:
            begin
                if (issue_reg < count)
                begin
                    cmd.issue  = 1'b1;
                    issue_next = issue_reg + 1'b1;
                end
                else
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                if (!status.pipe_busy)
                begin
                    cmd.finish = 1'b1;
                    state_next = IDLE;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            issue_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jpdr_dp.sv =====
`default_nettype none

module jpdr_dp #(
    parameter int MAX_PARTONS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire jpdr_pkg::cmd_t                cmd,
    input  wire logic [((MAX_PARTONS > 1) ? $clog2(MAX_PARTONS) : 1)-1:0] rd_addr,
    input  wire logic signed [jpdr_pkg::EtaW-1:0] in_eta,
    input  wire logic signed [jpdr_pkg::PhiW-1:0] in_phi,
    input  wire logic                          in_first,
    input  wire logic                          cfg_we,
    input  wire logic [jpdr_pkg::DistW-1:0]    cfg_data,
    input  wire logic                          out_ready,
    output jpdr_pkg::status_t                  status,
    output logic [$clog2(MAX_PARTONS + 1)-1:0] count,
    output logic                               out_valid,
    output logic                               out_matched,
    output logic [jpdr_pkg::IndexW-1:0]        out_index,
    output logic [jpdr_pkg::DistW-1:0]         out_dist,
    output logic                               out_dropped
);

    localparam int AW = (MAX_PARTONS > 1) ? $clog2(MAX_PARTONS) : 1;
    localparam int CW = $clog2(MAX_PARTONS + 1);
    localparam int EW = jpdr_pkg::EtaW;
    localparam int PW = jpdr_pkg::PhiW;
    localparam int DW = jpdr_pkg::DistW;
    localparam int SW = jpdr_pkg::SumW;
    localparam int IW = jpdr_pkg::IndexW;

    // parton table and set bookkeeping
    logic [CW-1:0]    count_reg, count_next;
    logic             ovf_reg, ovf_next;
    logic [DW-1:0]    max_reg;
    logic             room;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [AW+CW-1:0] cnt_ext;
    logic [EW+PW-1:0] rd_data;

    assign room    = count_reg < CW'(MAX_PARTONS);
    assign cnt_ext = {{AW{1'b0}}, count_reg};
    assign wr_en   = cmd.store && (in_first || room);
    assign wr_addr = in_first ? '0 : cnt_ext[AW-1:0];
    assign count   = count_reg;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (cmd.store)
        begin
            if (in_first)
            begin
                count_next = CW'(1);
                ovf_next   = 1'b0;
            end
            else if (room)
            begin
                count_next = count_reg + 1'b1;
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    jpdr_ram #(
        .WIDTH (EW + PW),
        .DEPTH (MAX_PARTONS)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata ({in_phi, in_eta}),
        .re    (cmd.issue),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // scan pipeline
    logic signed [EW-1:0] jet_eta_reg;
    logic signed [PW-1:0] jet_phi_reg;
    logic                 v1_reg, v2_reg, v3_reg;
    logic [AW-1:0]        idx1_reg, idx2_reg, idx3_reg;
    logic signed [EW:0]   de_reg;
    logic signed [11:0]   dp_reg;
    logic [23:0]          de2_reg;
    logic [19:0]          dp2_reg;

    logic signed [EW-1:0] st_eta;
    logic signed [PW-1:0] st_phi;
    logic signed [EW:0]   de;
    logic signed [11:0]   dphi;
    logic [11:0]          dabs;
    logic signed [11:0]   dp;
    logic signed [2*EW+1:0] de_sq;
    logic signed [23:0]   dp_sq;

    assign st_eta = rd_data[EW-1:0];
    assign st_phi = rd_data[EW+PW-1:EW];
    assign de     = {jet_eta_reg[EW-1], jet_eta_reg} - {st_eta[EW-1], st_eta};
    assign dphi   = {jet_phi_reg[PW-1], jet_phi_reg} - {st_phi[PW-1], st_phi};
    assign dabs   = dphi[11] ? 12'(-dphi) : dphi;
    assign dp     = (dabs <= jpdr_pkg::PiFix) ? dabs : (jpdr_pkg::TwoPiFix - dabs);
    assign de_sq  = de_reg * de_reg;
    assign dp_sq  = dp_reg * dp_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            jet_eta_reg <= in_eta;
            jet_phi_reg <= in_phi;
        end
        idx1_reg <= rd_addr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        de_reg   <= de;
        dp_reg   <= dp;
        de2_reg  <= de_sq[23:0];
        dp2_reg  <= dp_sq[19:0];
    end

    // nearest search
    logic              found_reg, found_next;
    logic [SW-1:0]     best_d_reg, best_d_next;
    logic [AW-1:0]     best_i_reg, best_i_next;
    logic [SW-1:0]     cur_dist;
    logic [AW+IW-1:0]  best_i_ext;

    assign cur_dist   = {1'b0, de2_reg} + {5'b0, dp2_reg};
    assign best_i_ext = {{IW{1'b0}}, best_i_reg};

    always_comb
    begin
        found_next  = found_reg;
        best_d_next = best_d_reg;
        best_i_next = best_i_reg;
        if (cmd.start)
        begin
            found_next  = 1'b0;
            best_d_next = '0;
            best_i_next = '0;
        end
        else if (v3_reg && (cur_dist <= {2'b0, max_reg})
                 && (!found_reg || cur_dist < best_d_reg))
        begin
            found_next  = 1'b1;
            best_d_next = cur_dist;
            best_i_next = idx3_reg;
        end
    end

    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign status.out_busy  = out_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
            max_reg   <= jpdr_pkg::DistReset;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            found_reg <= 1'b0;
            out_valid <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
            if (cfg_we)
            begin
                max_reg <= cfg_data;
            end
            v1_reg    <= cmd.issue;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            found_reg <= found_next;
            if (cmd.finish)
            begin
                out_valid <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        best_d_reg <= best_d_next;
        best_i_reg <= best_i_next;
        if (cmd.finish)
        begin
            out_matched <= found_reg;
            out_index   <= found_reg ? best_i_ext[IW-1:0] : '0;
            out_dist    <= found_reg ? best_d_reg[DW-1:0] : '0;
            out_dropped <= ovf_reg;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/jet_parton_delta_r_match_top.sv =====
`default_nettype none

// channel   | direction | handshake                       | payload
// s_axis    | in        | s_tvalid / s_tready             | s_tdata, s_tuser
// m_axis    | out       | m_tvalid / m_tready             | m_tdata, m_tuser
// cfg       | in        | cfg_valid / cfg_ready           | cfg_data
//
// a match item scans every stored parton, paced by the single table read port
// reading one parton a cycle into a three stage distance pipeline
// reset clears the set count, the dropped flag and the output valid flag;
// the radius returns to 0.4 squared
// input is held off while a match runs or while a result waits and m_tready is low

module jet_parton_delta_r_match_top #(
    parameter int MAX_PARTONS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // eta[11:0], phi[22:12], zero pad
    input  wire logic [1:0]  s_tuser,   // op[0], first_parton[1]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // parton_index[3:0], distance_sq[26:4], zero pad
    output logic [1:0]       m_tuser,   // matched[0], partons_dropped[1]
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [22:0] cfg_data
);

    localparam int AW = (MAX_PARTONS > 1) ? $clog2(MAX_PARTONS) : 1;
    localparam int CW = $clog2(MAX_PARTONS + 1);

    jpdr_pkg::cmd_t    cmd;
    jpdr_pkg::status_t status;
    logic [AW-1:0]     rd_addr;
    logic [CW-1:0]     count;
    logic              matched;
    logic [3:0]        parton_index;
    logic [22:0]       distance_sq;
    logic              partons_dropped;

    assign cfg_ready = 1'b1;

    jpdr_ctrl #(
        .MAX_PARTONS (MAX_PARTONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_op     (s_tuser[0]),
        .out_ready (m_tready),
        .status    (status),
        .count     (count),
        .in_ready  (s_tready),
        .cmd       (cmd),
        .rd_addr   (rd_addr)
    );

    jpdr_dp #(
        .MAX_PARTONS (MAX_PARTONS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .rd_addr     (rd_addr),
        .in_eta      (s_tdata[11:0]),
        .in_phi      (s_tdata[22:12]),
        .in_first    (s_tuser[1]),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .out_ready   (m_tready),
        .status      (status),
        .count       (count),
        .out_valid   (m_tvalid),
        .out_matched (matched),
        .out_index   (parton_index),
        .out_dist    (distance_sq),
        .out_dropped (partons_dropped)
    );

    assign m_tdata = {5'b0, distance_sq, parton_index};
    assign m_tuser = {partons_dropped, matched};

endmodule

`default_nettype wire

// ===== bench/jet_parton_delta_r_match_top_tb.sv =====
`timescale 1ns / 1ps

module jet_parton_delta_r_match_top_tb;

    localparam int EtaW   = jpdr_pkg::EtaW;
    localparam int PhiW   = jpdr_pkg::PhiW;
    localparam int DistW  = jpdr_pkg::DistW;
    localparam int IndexW = jpdr_pkg::IndexW;
    localparam logic [11:0] PiFix    = jpdr_pkg::PiFix;
    localparam logic [11:0] TwoPiFix = jpdr_pkg::TwoPiFix;
    localparam logic [DistW-1:0] DistReset = jpdr_pkg::DistReset;

    localparam int TableDepth = 16;
    localparam int SettleCycles = 30;
    localparam int TailCycles = 40;
    localparam int HoldCycles = 400;
    localparam int Limit = 600000;
    localparam logic [DistW-1:0] RadiusMax = 23'd7200016;

    typedef enum logic {
        OP_STORE = 1'b0,
        OP_MATCH = 1'b1
    } parton_op_e;

    typedef struct packed {
        logic              matched;
        logic [IndexW-1:0] parton_index;
        logic [DistW-1:0]  distance_sq;
        logic              dropped;
    } match_result_t;

    class delta_r_scoreboard;
        logic signed [EtaW-1:0] eta_tab [TableDepth];
        logic signed [PhiW-1:0] phi_tab [TableDepth];
        int                     n_stored;
        logic                   dropped;
        logic [DistW-1:0]       radius;
        match_result_t          pending [$];
        int                     errors;

        function new();
            n_stored = 0;
            dropped  = 1'b0;
            radius   = DistReset;
            errors   = 0;
        endfunction

        function void note_item(parton_op_e op, logic signed [EtaW-1:0] eta,
                                logic signed [PhiW-1:0] phi, logic first);
            match_result_t r;
            int            de;
            int            dp;
            int            d;
            int            best;
            bit            found;
            if (op == OP_STORE)
            begin
                if (first)
                begin
                    n_stored = 0;
                    dropped  = 1'b0;
                end
                if (n_stored < TableDepth)
                begin
                    eta_tab[n_stored] = eta;
                    phi_tab[n_stored] = phi;
                    n_stored++;
                end
                else
                    dropped = 1'b1;
                return;
            end
            r     = '0;
            found = 1'b0;
            best  = 0;
            for (int i = 0; i < n_stored; i++)
            begin
                de = int'(eta) - int'(eta_tab[i]);
                dp = int'(phi) - int'(phi_tab[i]);
                if (dp < 0)
                    dp = -dp;
                // single fold step, may go negative for out-of-range phi
                if (dp > int'(PiFix))
                    dp = int'(TwoPiFix) - dp;
                d = de * de + dp * dp;
                if (d <= int'(radius) && (!found || d < best))
                begin
                    found          = 1'b1;
                    best           = d;
                    r.parton_index = IndexW'(i);
                    r.distance_sq  = DistW'(d);
                end
            end
            r.matched = found;
            r.dropped = dropped;
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(logic [31:0] tdata, logic [1:0] tuser);
            match_result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result item with none pending: tdata %h tuser %b", tdata, tuser);
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            if (tuser[0] !== exp_r.matched)
            begin
                $error("matched: expected %0d, got %0d", exp_r.matched, tuser[0]);
                errors++;
            end
            if (tdata[IndexW-1:0] !== exp_r.parton_index)
            begin
                $error("parton_index: expected %0d, got %0d",
                       exp_r.parton_index, tdata[IndexW-1:0]);
                errors++;
            end
            if (tdata[IndexW+DistW-1:IndexW] !== exp_r.distance_sq)
            begin
                $error("distance_sq: expected %0d, got %0d",
                       exp_r.distance_sq, tdata[IndexW+DistW-1:IndexW]);
                errors++;
            end
            if (tuser[1] !== exp_r.dropped)
            begin
                $error("partons_dropped: expected %0d, got %0d", exp_r.dropped, tuser[1]);
                errors++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [22:0] cfg_data;

    delta_r_scoreboard sb;
    int                items_sent;
    int                cycle_count;
    int                hold_request;
    bit                quiet_mode;

    jet_parton_delta_r_match_top #(
        .MAX_PARTONS(TableDepth)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= Limit)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic int draw_gap();
        return quiet_mode ? 0 : int'($urandom_range(0, 8));
    endfunction

    function automatic int jitter(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic int clamp_eta(int v);
        return (v > 1280) ? 1280 : (v < -1280) ? -1280 : v;
    endfunction

    function automatic int wrap_phi(int v);
        return (v > 804) ? v - 1608 : (v < -804) ? v + 1608 : v;
    endfunction

    // receive side: random stalls, one long hold-off on request
    initial
    begin
        int n;
        m_tready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_request > 0)
            begin
                n = hold_request;
                hold_request = 0;
            end
            else
                n = draw_gap();
            if (n > 0)
            begin
                m_tready <= 1'b0;
                repeat (n) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
            sb.check_result(m_tdata, m_tuser);
        end
    end

    task automatic send_item(parton_op_e op, logic signed [EtaW-1:0] eta,
                             logic signed [PhiW-1:0] phi, logic first);
        int n;
        n = draw_gap();
        if (n > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, phi, eta};
        s_tuser  <= {first, op};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(op, eta, phi, first);
        items_sent++;
    endtask

    task automatic idle_input();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained();
        while (sb.pending.size() != 0)
            @(posedge clk);
    endtask

    task automatic set_radius(logic [DistW-1:0] value);
        idle_input();
        wait_drained();
        repeat (SettleCycles) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        sb.radius = value;
    endtask

    // mostly well-formed sets followed by jets near stored partons, some noise
    task automatic run_random(int n_items);
        int start;
        int k;
        int m;
        int spread;
        int ce;
        int cp;
        int pick;
        int off;
        int set_eta [TableDepth];
        int set_phi [TableDepth];
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            if ($urandom_range(0, 4) == 0)
                send_item(parton_op_e'($urandom_range(0, 1)), EtaW'($urandom),
                          PhiW'($urandom), 1'($urandom));
            else
            begin
                k = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 22)
                                                : $urandom_range(1, TableDepth);
                case ($urandom_range(0, 3))
                    0:       spread = 0;
                    1:       spread = 60;
                    2:       spread = 400;
                    default: spread = 2000;
                endcase
                ce = int'($urandom_range(0, 2560)) - 1280;
                cp = int'($urandom_range(0, 1608)) - 804;
                for (int j = 0; j < k; j++)
                begin
                    if (j < TableDepth)
                    begin
                        set_eta[j] = clamp_eta(ce + jitter(spread));
                        set_phi[j] = wrap_phi(cp + jitter(spread));
                        send_item(OP_STORE, EtaW'(set_eta[j]), PhiW'(set_phi[j]), j == 0);
                    end
                    else
                        send_item(OP_STORE, EtaW'(clamp_eta(ce + jitter(spread))),
                                  PhiW'(wrap_phi(cp + jitter(spread))), 1'b0);
                end
                m = $urandom_range(1, 4);
                for (int j = 0; j < m; j++)
                begin
                    pick = $urandom_range(0, ((k < TableDepth) ? k : TableDepth) - 1);
                    case ($urandom_range(0, 3))
                        0:       off = 0;
                        1:       off = 40;
                        2:       off = 150;
                        default: off = 1600;
                    endcase
                    send_item(OP_MATCH, EtaW'(clamp_eta(set_eta[pick] + jitter(off))),
                              PhiW'(wrap_phi(set_phi[pick] + jitter(off))),
                              1'($urandom));
                end
            end
        end
    endtask

    initial
    begin
        sb = new();
        items_sent   = 0;
        cycle_count  = 0;
        hold_request = 0;
        quiet_mode   = 1'b0;
        rst_n     <= 1'b0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        s_tuser   <= '0;
        cfg_valid <= 1'b0;
        cfg_data  <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset radius: empty table, ties, phi wrap, overflow, restart
        send_item(OP_MATCH, 0, 0, 1'b0);
        send_item(OP_STORE, -1280, -804, 1'b1);
        send_item(OP_STORE, 1280, 804, 1'b0);
        send_item(OP_STORE, 0, 0, 1'b0);
        send_item(OP_STORE, 0, 0, 1'b0);
        send_item(OP_STORE, 100, 800, 1'b0);
        send_item(OP_MATCH, 0, 0, 1'b0);
        send_item(OP_MATCH, 100, -800, 1'b0);
        send_item(OP_MATCH, -1280, -804, 1'b0);
        send_item(OP_MATCH, 1280, -804, 1'b0);
        send_item(OP_MATCH, 50, 50, 1'b1);
        send_item(OP_MATCH, 600, 0, 1'b0);
        for (int j = 0; j < 12; j++)
            send_item(OP_STORE, EtaW'(j * 100 - 600), PhiW'(j * 130 - 700), 1'b0);
        send_item(OP_MATCH, -600, -700, 1'b0);
        send_item(OP_STORE, 10, 20, 1'b1);
        send_item(OP_MATCH, 10, 20, 1'b0);

        // widest radius: angles beyond the stated range
        set_radius('1);
        send_item(OP_STORE, -2048, -1024, 1'b1);
        send_item(OP_STORE, 2047, 1023, 1'b0);
        send_item(OP_MATCH, 2047, 1023, 1'b0);
        send_item(OP_MATCH, -2048, 1023, 1'b0);
        send_item(OP_MATCH, 2047, -1024, 1'b0);
        run_random(300);

        quiet_mode = 1'b1;
        set_radius('0);
        run_random(300);

        quiet_mode = 1'b0;
        set_radius(RadiusMax);
        hold_request = HoldCycles;
        run_random(300);

        set_radius(DistW'($urandom_range(1000, 60000)));
        run_random(150);
        idle_input();
        wait_drained();
        run_random(150);

        quiet_mode = 1'b1;
        set_radius(DistReset);
        run_random(300);

        quiet_mode = 1'b0;
        set_radius(DistW'($urandom));
        run_random(300);

        idle_input();
        wait_drained();
        repeat (TailCycles) @(posedge clk);
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/jpdr_pkg.sv
rtl/jpdr_ram.sv
rtl/jpdr_ctrl.sv
rtl/jpdr_dp.sv
rtl/jet_parton_delta_r_match_top.sv
bench/jet_parton_delta_r_match_top_tb.sv
